// ===== sv/efdr_pkg.sv =====
// Shared constants, payload types and helper types for the event frame decay renderer.
package efdr_pkg;

   localparam int TIME_BITS   = 48;
   localparam int GRID_BITS   = 7;
   localparam int GRID_SIZE   = 1 << GRID_BITS;
   localparam int CELL_BITS   = 2 * GRID_BITS;
   localparam int CELLS       = 1 << CELL_BITS;
   localparam int DECAY_BITS  = 24;
   localparam int SEL_BITS    = 8;
   localparam int GREY_BITS   = 8;
   localparam int QUOT_BITS   = 7;
   localparam int STEP_BITS   = $clog2(QUOT_BITS);
   localparam int NUM_BITS    = DECAY_BITS + QUOT_BITS;
   localparam int ENTRY_BITS  = TIME_BITS + 2;
   localparam int ADDR_BITS   = 3;
   localparam int DATA_BITS   = 32;

   localparam logic [DECAY_BITS-1:0] DECAY_RESET = 24'd100000;
   localparam logic [GREY_BITS-1:0]  GREY_EMPTY  = 8'd128;
   localparam logic [GREY_BITS-1:0]  GREY_WHITE  = 8'd255;

   localparam logic FUNC_EVENT = 1'b0;
   localparam logic FUNC_READ  = 1'b1;

   localparam logic REG_DECAY  = 1'b0;
   localparam logic REG_SELECT = 1'b1;

   typedef struct packed {
      logic                      func;
      logic [TIME_BITS-1:0]      stamp;
      logic signed [15:0]        x_pos;
      logic signed [15:0]        y_pos;
      logic                      polarity;
      logic [SEL_BITS-1:0]       sensor_id;
      logic [6:0]                read_col;
      logic [6:0]                read_row;
   } req_type;

   typedef struct packed {
      logic [GREY_BITS-1:0] pixel_value;
      logic                 frame_nonempty;
   } rsp_type;

   // classified operation handed from front to back
   typedef struct packed {
      logic                  is_read;
      logic                  pol;
      logic [CELL_BITS-1:0]  pix_addr;
      logic [TIME_BITS-1:0]  stamp;
      logic                  flag;
      logic                  in_grid;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

   typedef struct packed {
      logic clearing;
      logic pop;
   } back_status_type;

endpackage

// ===== sv/event_frame_decay_renderer_top.sv =====
// Top level: register port, front end, queue and back end of the frame decay renderer.
// A pixel read that hits in the window passes the lookup and scale states and the 7-step
// radix-2 fade divider before its result strobes; any other read is answered after the
// lookup, plus queue wait. The back end takes no new item while it works on a read; events
// are written as they are popped. The two-entry queue lets the front take transfers while
// the back end works. Reset (synchronous) starts a clearing pass over all 16384 cells of
// the pixel store; busy stays high until it ends. The receiver cannot stall results.
module event_frame_decay_renderer_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  efdr_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   output efdr_pkg::rsp_type                     rsp_data,
   input  logic                                  psel,
   input  logic                                  penable,
   input  logic                                  pwrite,
   input  logic [efdr_pkg::ADDR_BITS-1:0]        paddr,
   input  logic [efdr_pkg::DATA_BITS-1:0]        pwdata,
   output logic [efdr_pkg::DATA_BITS-1:0]        prdata,
   output logic                                  pready
);

   logic [efdr_pkg::DECAY_BITS-1:0] decay_ff, decay_in;
   logic [efdr_pkg::SEL_BITS-1:0]   select_ff, select_in;
   logic                            reg_idx;
   logic                            csr_write;
   logic                            accept;
   logic                            push;
   logic                            full;
   efdr_pkg::item_type              push_item;
   efdr_pkg::queue_out_type         head;
   efdr_pkg::back_status_type       status;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      decay_in  = decay_ff;
      select_in = select_ff;
      prdata    = '0;
      unique case (reg_idx)
         efdr_pkg::REG_DECAY: begin
            prdata = efdr_pkg::DATA_BITS'(decay_ff);
            if (csr_write) begin
               decay_in = pwdata[efdr_pkg::DECAY_BITS-1:0];
            end
         end
         efdr_pkg::REG_SELECT: begin
            prdata = efdr_pkg::DATA_BITS'(select_ff);
            if (csr_write) begin
               select_in = pwdata[efdr_pkg::SEL_BITS-1:0];
            end
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decay_ff  <= efdr_pkg::DECAY_RESET;
         select_ff <= '0;
      end else begin
         decay_ff  <= decay_in;
         select_ff <= select_in;
      end
   end

   assign busy   = status.clearing || full;
   assign accept = start && !busy;

   efdr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .decay    (decay_ff),
      .select   (select_ff),
      .push     (push),
      .item     (push_item)
   );

   efdr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (status.pop),
      .head      (head),
      .full      (full)
   );

   efdr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .decay     (decay_ff),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // results are never strobed back to back
   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobes on consecutive cycles");

   // a push never lands on a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue overflow");

   // the store is swept after reset before anything is taken
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> busy)
      else $error("not busy after reset");

   // no pop and no result while the store is being cleared
   a_no_pop_clearing: assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> !status.pop && !rsp_valid)
      else $error("back end active during clearing pass");

endmodule

// ===== sv/efdr_front.sv =====
// Front end: classifies accepted items, tracks the latest event time and computes the flag.
module efdr_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  efdr_pkg::req_type                   req_data,
   input  logic [efdr_pkg::DECAY_BITS-1:0]     decay,
   input  logic [efdr_pkg::SEL_BITS-1:0]       select,
   output logic                                push,
   output efdr_pkg::item_type                  item
);

   logic                               any_valid_ff, any_valid_in;
   logic [efdr_pkg::TIME_BITS-1:0]     any_time_ff, any_time_in;
   logic [efdr_pkg::TIME_BITS:0]       age;
   logic                               window;
   logic [efdr_pkg::GRID_BITS-1:0]     gx, gy;
   logic                               is_read;

   // round to nearest (+1/2, floor) and clamp to the grid
   function automatic logic [efdr_pkg::GRID_BITS-1:0] grid_coord(input logic signed [15:0] pos);
      logic signed [16:0] v;
      logic signed [12:0] q;
      v = {pos[15], pos} + 17'sd8;
      q = v[16:4];
      if (q < 13'sd0) begin
         grid_coord = '0;
      end else if (q > $signed(13'(efdr_pkg::GRID_SIZE - 1))) begin
         grid_coord = efdr_pkg::GRID_BITS'(efdr_pkg::GRID_SIZE - 1);
      end else begin
         grid_coord = q[efdr_pkg::GRID_BITS-1:0];
      end
   endfunction

   assign is_read = (req_data.func == efdr_pkg::FUNC_READ);
   assign gx      = grid_coord(req_data.x_pos);
   assign gy      = grid_coord(req_data.y_pos);

   // in window: 0 < frame - t <= decay
   assign age    = {1'b0, req_data.stamp} - {1'b0, any_time_ff};
   assign window = !age[efdr_pkg::TIME_BITS] && (age != '0) &&
                   (age[efdr_pkg::TIME_BITS-1:0] <= efdr_pkg::TIME_BITS'(decay));

   always_comb begin
      item.is_read = is_read;
      item.pol     = req_data.polarity;
      item.stamp   = req_data.stamp;
      item.flag    = any_valid_ff && window;
      item.in_grid = (32'(req_data.read_col) < efdr_pkg::GRID_SIZE) &&
                     (32'(req_data.read_row) < efdr_pkg::GRID_SIZE);
      if (is_read) begin
         item.pix_addr = {efdr_pkg::GRID_BITS'(req_data.read_row),
                          efdr_pkg::GRID_BITS'(req_data.read_col)};
      end else begin
         item.pix_addr = {gy, gx};
      end
   end

   // foreign events are dropped here, reads always go on
   assign push = accept && (is_read || (req_data.sensor_id == select));

   always_comb begin
      any_valid_in = any_valid_ff;
      any_time_in  = any_time_ff;
      if (accept && !is_read) begin
         any_valid_in = 1'b1;
         any_time_in  = req_data.stamp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         any_valid_ff <= 1'b0;
      end else begin
         any_valid_ff <= any_valid_in;
      end
      any_time_ff <= any_time_in;
   end

endmodule

// ===== sv/efdr_queue.sv =====
// Two-entry queue between the front end and the back end.
module efdr_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  efdr_pkg::item_type      push_item,
   input  logic                    pop,
   output efdr_pkg::queue_out_type head,
   output logic                    full
);

   efdr_pkg::item_type slot_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head.valid = (count_ff != 2'd0);
   assign head.item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== sv/efdr_back.sv =====
// Back end: pixel store with clearing pass, window check and radix-2 fade divider.
module efdr_back (
   input  logic                                clock,
   input  logic                                reset,
   input  efdr_pkg::queue_out_type             head,
   input  logic [efdr_pkg::DECAY_BITS-1:0]     decay,
   output efdr_pkg::back_status_type           status,
   output logic                                rsp_valid,
   output efdr_pkg::rsp_type                   rsp_data
);

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_LOOK  = 5'b00100,
      S_SCALE = 5'b01000,
      S_DIV   = 5'b10000
   } state_type;

   logic [efdr_pkg::ENTRY_BITS-1:0] mem [efdr_pkg::CELLS];

   state_type                          state_ff, state_in;
   logic [efdr_pkg::CELL_BITS-1:0]     clr_ff, clr_in;
   logic [efdr_pkg::ENTRY_BITS-1:0]    rd_data_ff;
   logic [efdr_pkg::TIME_BITS-1:0]     stamp_ff, stamp_in;
   logic                               flag_ff, flag_in;
   logic                               grid_ff, grid_in;
   logic                               pol_ff, pol_in;
   logic [efdr_pkg::DECAY_BITS-1:0]    age_ff, age_in;
   logic [efdr_pkg::NUM_BITS-1:0]      rem_ff, rem_in;
   logic [efdr_pkg::NUM_BITS-1:0]      div_ff, div_in;
   logic [efdr_pkg::QUOT_BITS-1:0]     quot_ff, quot_in;
   logic [efdr_pkg::STEP_BITS-1:0]     step_ff, step_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   efdr_pkg::rsp_type                  rsp_data_ff, rsp_data_in;

   logic                               wr_en, rd_en;
   logic [efdr_pkg::CELL_BITS-1:0]     wr_addr, rd_addr;
   logic [efdr_pkg::ENTRY_BITS-1:0]    wr_data;

   logic                               e_valid, e_pol;
   logic [efdr_pkg::TIME_BITS-1:0]     e_time;
   logic [efdr_pkg::TIME_BITS:0]       age;
   logic                               hit;
   logic                               pop;

   assign {e_valid, e_pol, e_time} = rd_data_ff;
   assign age = {1'b0, stamp_ff} - {1'b0, e_time};
   assign hit = e_valid && grid_ff && !age[efdr_pkg::TIME_BITS] && (age != '0) &&
                (age[efdr_pkg::TIME_BITS-1:0] <= efdr_pkg::TIME_BITS'(decay));

   assign pop             = (state_ff == S_IDLE) && head.valid;
   assign status.pop      = pop;
   assign status.clearing = (state_ff == S_CLEAR);

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      stamp_in     = stamp_ff;
      flag_in      = flag_ff;
      grid_in      = grid_ff;
      pol_in       = pol_ff;
      age_in       = age_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      quot_in      = quot_ff;
      step_in      = step_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = head.item.pix_addr;
      wr_data      = {1'b1, head.item.pol, head.item.stamp};
      rd_en        = 1'b0;
      rd_addr      = head.item.pix_addr;
      unique case (state_ff)
         S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + efdr_pkg::CELL_BITS'(1);
            if (&clr_ff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (pop) begin
               if (head.item.is_read) begin
                  rd_en    = 1'b1;
                  stamp_in = head.item.stamp;
                  flag_in  = head.item.flag;
                  grid_in  = head.item.in_grid;
                  state_in = S_LOOK;
               end else begin
                  wr_en = 1'b1;
               end
            end
         end
         S_LOOK: begin
            if (hit) begin
               age_in   = age[efdr_pkg::DECAY_BITS-1:0];
               pol_in   = e_pol;
               state_in = S_SCALE;
            end else begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.pixel_value     = efdr_pkg::GREY_EMPTY;
               rsp_data_in.frame_nonempty  = flag_ff;
               state_in                    = S_IDLE;
            end
         end
         S_SCALE: begin
            // 127 * age as (age << 7) - age
            rem_in   = {age_ff, efdr_pkg::QUOT_BITS'(0)} - efdr_pkg::NUM_BITS'(age_ff);
            div_in   = efdr_pkg::NUM_BITS'({decay, (efdr_pkg::QUOT_BITS - 1)'(0)});
            quot_in  = '0;
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (rem_ff >= div_ff) begin
               rem_in  = rem_ff - div_ff;
               quot_in = {quot_ff[efdr_pkg::QUOT_BITS-2:0], 1'b1};
            end else begin
               quot_in = {quot_ff[efdr_pkg::QUOT_BITS-2:0], 1'b0};
            end
            div_in  = div_ff >> 1;
            step_in = step_ff + efdr_pkg::STEP_BITS'(1);
            if (step_ff == efdr_pkg::STEP_BITS'(efdr_pkg::QUOT_BITS - 1)) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.frame_nonempty = flag_ff;
               if (pol_ff) begin
                  rsp_data_in.pixel_value = efdr_pkg::GREY_WHITE -
                                            efdr_pkg::GREY_BITS'(quot_in);
               end else begin
                  rsp_data_in.pixel_value = efdr_pkg::GREY_BITS'(quot_in);
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      stamp_ff    <= stamp_in;
      flag_ff     <= flag_in;
      grid_ff     <= grid_in;
      pol_ff      <= pol_in;
      age_ff      <= age_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      quot_ff     <= quot_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
